// ----- hdl/axis_angle_point_rotate_core_macros.svh -----
// Assertion macros for the axis-angle point rotation core.
// Used by the top level only; no other dependencies.
`ifndef AXIS_ANGLE_POINT_ROTATE_CORE_MACROS_SVH
`define AXIS_ANGLE_POINT_ROTATE_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define AAPR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define AAPR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define AAPR_ASSERT_NOW(label, clk, rst, ante, cons)
`define AAPR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- hdl/aapr_pkg.sv -----
// Package for the axis-angle point rotation core: widths, sine table.
// No dependencies.
package aapr_pkg;

   localparam int SINE_TABLE_BITS = 10;
   localparam int SINE_N = 1 << SINE_TABLE_BITS;
   localparam int IDX_W = SINE_TABLE_BITS + 1;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef logic [14:0] sine_table_type [0:SINE_N];

   // Quarter-wave sine table, Q1.14, built by a Taylor series in Q.30
   function automatic sine_table_type build_sine_table();
      sine_table_type t;
      logic [63:0] theta;
      logic [63:0] th2;
      logic [63:0] term;
      logic signed [63:0] sum;
      logic signed [63:0] rnd;
      for (int i = 0; i <= SINE_N; i++) begin
         theta = (64'(i) * HALF_PI_Q30) >> SINE_TABLE_BITS;
         th2 = (theta * theta) >> 30;
         term = theta;
         sum = $signed(theta);
         for (int k = 1; k <= 8; k++) begin
            unique case (k)
               1: term = ((term * th2) >> 30) / 64'd6;
               2: term = ((term * th2) >> 30) / 64'd20;
               3: term = ((term * th2) >> 30) / 64'd42;
               4: term = ((term * th2) >> 30) / 64'd72;
               5: term = ((term * th2) >> 30) / 64'd110;
               6: term = ((term * th2) >> 30) / 64'd156;
               7: term = ((term * th2) >> 30) / 64'd210;
               default: term = ((term * th2) >> 30) / 64'd272;
            endcase
            if (k % 2 == 1) sum = sum - $signed(term);
            else sum = sum + $signed(term);
         end
         if (sum < 0) sum = 0;
         rnd = (sum + 64'sd32768) >>> 16;
         if (rnd > 64'sd16384) rnd = 64'sd16384;
         t[i] = rnd[14:0];
      end
      return t;
   endfunction

   localparam sine_table_type SINE_TABLE = build_sine_table();

endpackage

// ----- hdl/aapr_if.sv -----
// Request and response channel interfaces of the rotation core.
// Depends on nothing.
interface aapr_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] point_x;
   logic signed [31:0] point_y;
   logic signed [31:0] point_z;
   logic signed [15:0] axis_a;
   logic signed [15:0] axis_b;
   logic signed [15:0] axis_c;
   logic [15:0]        angle_phase;
   modport source (output valid, point_x, point_y, point_z, axis_a, axis_b, axis_c,
                   angle_phase, input ready);
   modport sink (input valid, point_x, point_y, point_z, axis_a, axis_b, axis_c,
                 angle_phase, output ready);
endinterface

interface aapr_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] rotated_x;
   logic signed [31:0] rotated_y;
   logic signed [31:0] rotated_z;
   modport source (output valid, rotated_x, rotated_y, rotated_z, input ready);
   modport sink (input valid, rotated_x, rotated_y, rotated_z, output ready);
endinterface

// ----- hdl/axis_angle_point_rotate_core.sv -----
// Axis-angle (Rodrigues) point rotation core, top level.
// Depends on aapr_pkg, aapr_if.sv and axis_angle_point_rotate_core_macros.svh.
//
// Usage: req_if carries a Q16.16 point, a Q1.14 unit axis and a 16-bit angle
// phase (65536 = one turn); rsp_if returns the rotated point, Q16.16,
// saturated per coordinate. Both use valid/ready; a request moves on a
// clock edge where both are high.
// Pipeline: five register stages (sine/cosine ROM read, axis products,
// matrix entries, point-times-entry products, sum/round/saturate into the
// output register). One request per cycle is sustained while rsp_if
// takes it; the figure is set by the per-stage handshake, every stage
// takes new data each cycle while nothing downstream stalls.
// Each stage holds while its successor is full and stalled, so a stall on
// rsp_if backs up stage by stage; bubbles are squeezed out and nothing is
// lost or repeated. req_if.ready stays high while stage one can move.
// Reset (synchronous, active high) empties all stages; no clearing pass.
`include "axis_angle_point_rotate_core_macros.svh"

module axis_angle_point_rotate_core (
   input logic        clock,
   input logic        reset,
   aapr_req_if.sink   req_if,
   aapr_rsp_if.source rsp_if
);

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } point_type;

   // stage valids and ready chain
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;
   logic s1_rdy, s2_rdy, s3_rdy, s4_rdy, s5_rdy;

   assign s5_rdy = !s5_valid_ff || rsp_if.ready;
   assign s4_rdy = !s4_valid_ff || s5_rdy;
   assign s3_rdy = !s3_valid_ff || s4_rdy;
   assign s2_rdy = !s2_valid_ff || s3_rdy;
   assign s1_rdy = !s1_valid_ff || s2_rdy;
   assign req_if.ready = s1_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         if (s1_rdy) s1_valid_ff <= req_if.valid;
         if (s2_rdy) s2_valid_ff <= s1_valid_ff;
         if (s3_rdy) s3_valid_ff <= s2_valid_ff;
         if (s4_rdy) s4_valid_ff <= s3_valid_ff;
         if (s5_rdy) s5_valid_ff <= s4_valid_ff;
      end
   end

   // Stage 1: table indices and ROM read
   logic [1:0]                          q_sin_in, q_cos_in;
   logic [aapr_pkg::SINE_TABLE_BITS-1:0] r_in;
   logic [aapr_pkg::IDX_W-1:0]          idx_sin_in, idx_cos_in;
   logic [14:0]                         sin_raw_ff, cos_raw_ff;
   logic                                sin_neg_ff, cos_neg_ff;
   point_type                           s1_pt_ff;
   logic signed [15:0]                  s1_a_ff, s1_b_ff, s1_c_ff;

   assign q_sin_in = req_if.angle_phase[15:14];
   assign q_cos_in = q_sin_in + 2'd1;
   assign r_in = req_if.angle_phase[13 -: aapr_pkg::SINE_TABLE_BITS];
   assign idx_sin_in = q_sin_in[0] ? aapr_pkg::IDX_W'(aapr_pkg::SINE_N) - {1'b0, r_in}
                                   : {1'b0, r_in};
   assign idx_cos_in = q_cos_in[0] ? aapr_pkg::IDX_W'(aapr_pkg::SINE_N) - {1'b0, r_in}
                                   : {1'b0, r_in};

   always_ff @(posedge clock) begin
      if (s1_rdy) begin
         sin_raw_ff <= aapr_pkg::SINE_TABLE[idx_sin_in];
         cos_raw_ff <= aapr_pkg::SINE_TABLE[idx_cos_in];
         sin_neg_ff <= q_sin_in[1];
         cos_neg_ff <= q_cos_in[1];
         s1_pt_ff   <= '{req_if.point_x, req_if.point_y, req_if.point_z};
         s1_a_ff    <= req_if.axis_a;
         s1_b_ff    <= req_if.axis_b;
         s1_c_ff    <= req_if.axis_c;
      end
   end

   // Stage 2: signed sine/cosine, axis pair products, axis times sine
   logic signed [15:0] sn_in, cs_in;
   logic signed [15:0] cs_ff;
   logic signed [16:0] v_ff;
   logic signed [31:0] aa_ff, bb_ff, cc_ff, ab_ff, ac_ff, bc_ff;
   logic signed [31:0] xs_ff, ys_ff, zs_ff;
   point_type          s2_pt_ff;

   assign sn_in = sin_neg_ff ? -$signed({1'b0, sin_raw_ff}) : $signed({1'b0, sin_raw_ff});
   assign cs_in = cos_neg_ff ? -$signed({1'b0, cos_raw_ff}) : $signed({1'b0, cos_raw_ff});

   always_ff @(posedge clock) begin
      if (s2_rdy) begin
         cs_ff    <= cs_in;
         v_ff     <= 17'sd16384 - 17'(cs_in);
         aa_ff    <= 32'(s1_a_ff) * 32'(s1_a_ff);
         bb_ff    <= 32'(s1_b_ff) * 32'(s1_b_ff);
         cc_ff    <= 32'(s1_c_ff) * 32'(s1_c_ff);
         ab_ff    <= 32'(s1_a_ff) * 32'(s1_b_ff);
         ac_ff    <= 32'(s1_a_ff) * 32'(s1_c_ff);
         bc_ff    <= 32'(s1_b_ff) * 32'(s1_c_ff);
         xs_ff    <= 32'(s1_a_ff) * 32'(sn_in);
         ys_ff    <= 32'(s1_b_ff) * 32'(sn_in);
         zs_ff    <= 32'(s1_c_ff) * 32'(sn_in);
         s2_pt_ff <= s1_pt_ff;
      end
   end

   // Stage 3: rotation matrix entries, Q.42 rounded to Q.24
   function automatic logic signed [29:0] round_entry(input logic signed [47:0] v);
      logic signed [47:0] t;
      t = (v + 48'sd131072) >>> 18;
      return t[29:0];
   endfunction

   function automatic logic signed [47:0] pv(input logic signed [31:0] p,
                                              input logic signed [16:0] v);
      return 48'(p) * 48'(v);
   endfunction

   logic signed [47:0] c42_in, xs14_in, ys14_in, zs14_in;
   logic signed [29:0] r_ff [3][3];
   point_type          s3_pt_ff;

   assign c42_in  = 48'(cs_ff) <<< 28;
   assign xs14_in = 48'(xs_ff) <<< 14;
   assign ys14_in = 48'(ys_ff) <<< 14;
   assign zs14_in = 48'(zs_ff) <<< 14;

   always_ff @(posedge clock) begin
      if (s3_rdy) begin
         r_ff[0][0] <= round_entry(pv(aa_ff, v_ff) + c42_in);
         r_ff[1][1] <= round_entry(pv(bb_ff, v_ff) + c42_in);
         r_ff[2][2] <= round_entry(pv(cc_ff, v_ff) + c42_in);
         r_ff[0][1] <= round_entry(pv(ab_ff, v_ff) - zs14_in);
         r_ff[1][0] <= round_entry(pv(ab_ff, v_ff) + zs14_in);
         r_ff[0][2] <= round_entry(pv(ac_ff, v_ff) + ys14_in);
         r_ff[2][0] <= round_entry(pv(ac_ff, v_ff) - ys14_in);
         r_ff[1][2] <= round_entry(pv(bc_ff, v_ff) - xs14_in);
         r_ff[2][1] <= round_entry(pv(bc_ff, v_ff) + xs14_in);
         s3_pt_ff   <= s2_pt_ff;
      end
   end

   // Stage 4: point times entries, Q.40
   logic signed [61:0] p_ff [3][3];

   always_ff @(posedge clock) begin
      if (s4_rdy) begin
         for (int i = 0; i < 3; i++) begin
            p_ff[i][0] <= 62'(s3_pt_ff.x) * 62'(r_ff[i][0]);
            p_ff[i][1] <= 62'(s3_pt_ff.y) * 62'(r_ff[i][1]);
            p_ff[i][2] <= 62'(s3_pt_ff.z) * 62'(r_ff[i][2]);
         end
      end
   end

   // Stage 5: sum, round to Q16.16, saturate into the output register
   function automatic logic signed [31:0] sum_sat(input logic signed [61:0] p0,
                                                   input logic signed [61:0] p1,
                                                   input logic signed [61:0] p2);
      logic signed [63:0] s;
      s = (64'(p0) + 64'(p1) + 64'(p2) + 64'sd8388608) >>> 24;
      if (s > 64'sd2147483647) return 32'sh7fffffff;
      if (s < -64'sd2147483648) return 32'sh80000000;
      return s[31:0];
   endfunction

   point_type out_ff;

   always_ff @(posedge clock) begin
      if (s5_rdy) begin
         out_ff.x <= sum_sat(p_ff[0][0], p_ff[0][1], p_ff[0][2]);
         out_ff.y <= sum_sat(p_ff[1][0], p_ff[1][1], p_ff[1][2]);
         out_ff.z <= sum_sat(p_ff[2][0], p_ff[2][1], p_ff[2][2]);
      end
   end

   assign rsp_if.valid     = s5_valid_ff;
   assign rsp_if.rotated_x = out_ff.x;
   assign rsp_if.rotated_y = out_ff.y;
   assign rsp_if.rotated_z = out_ff.z;

   // checks
   `AAPR_ASSERT_NEXT(a_accept_fills_s1, clock, reset, req_if.valid && req_if.ready,
      s1_valid_ff)
   `AAPR_ASSERT_NEXT(a_s1_holds, clock, reset, s1_valid_ff && !s2_rdy,
      s1_valid_ff && $stable(s1_pt_ff) && $stable(sin_raw_ff))
   `AAPR_ASSERT_NOW(a_full_chain_blocks, clock, reset, !req_if.ready,
      s1_valid_ff && s2_valid_ff && s3_valid_ff && s4_valid_ff && s5_valid_ff)
   `AAPR_ASSERT_NEXT(a_reset_empties, clock, 1'b0, reset, !rsp_if.valid)

endmodule
